[src/dmi_pkg.sv]
// Shared constants, state encoding and codes for the mutual information block.
`timescale 1ns / 1ps
`default_nettype none
package dmi_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int CLASS_W     = 4;
  localparam int LEVEL_W     = 2;
  localparam int NUM_LEVELS  = 3;
  localparam int NUM_CLASSES = 16;
  localparam int JOINT_DEPTH = NUM_LEVELS * NUM_CLASSES;
  localparam int JOINT_AW    = LEVEL_W + CLASS_W;
  localparam int CNT_W       = 17;
  localparam logic [CNT_W-1:0] MAX_SAMPLES = 17'd65536;

  localparam int FRAC_BITS = 16;
  localparam int MANT_BITS = 30;
  localparam int MANT_W    = MANT_BITS + 1;
  localparam int SQ_W      = 2 * MANT_W;
  localparam int EXP_W     = 5;
  localparam int LG_W      = EXP_W + FRAC_BITS;
  localparam int TERM_W    = CNT_W + LG_W;
  localparam int ACC_W     = 40;
  localparam int MI_W      = 18;
  localparam logic [MI_W-1:0] MI_MAX = 18'h3FFFF;

  localparam int SQ_CNT_W  = 5;
  localparam int DIV_CNT_W = 6;

  // Term sequence of the entropy pass
  localparam int K_W = 7;
  localparam logic [K_W-1:0] K_TOTAL = 7'd0;
  localparam logic [K_W-1:0] K_JOINT = 7'd1;
  localparam logic [K_W-1:0] K_LEVEL = 7'd49;
  localparam logic [K_W-1:0] K_CLASS = 7'd52;
  localparam logic [K_W-1:0] K_LAST  = 7'd67;

  localparam logic [LEVEL_W-1:0] LVL_ABOVE = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_BELOW = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_MID   = 2'd2;

  localparam int CFG_AW = 3;
  localparam logic REG_UPPER = 1'b0;
  localparam logic REG_LOWER = 1'b1;
  localparam logic [SAMPLE_W-1:0] UPPER_RST = 16'sd2048;
  localparam logic [SAMPLE_W-1:0] LOWER_RST = -16'sd2048;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD,
    S_FRD,
    S_FLD,
    S_SQ,
    S_MUL,
    S_ACC,
    S_CHK,
    S_DIV,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

[src/dmi_if.sv]
// Stream interfaces for sample words and result words.
`timescale 1ns / 1ps
`default_nettype none
interface dmi_in_if import dmi_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic        [CLASS_W-1:0]  class_label;
  logic                       last_sample;
  modport source (output valid, sample_value, class_label, last_sample, input ready);
  modport sink (input valid, sample_value, class_label, last_sample, output ready);
endinterface

interface dmi_out_if import dmi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MI_W-1:0]  mutual_info;
  logic [CNT_W-1:0] sample_count;
  logic             count_overflow;
  modport source (output valid, mutual_info, sample_count, count_overflow, input ready);
  modport sink (input valid, mutual_info, sample_count, count_overflow, output ready);
endinterface
`default_nettype wire

[src/dmi_ram.sv]
// Generic simple dual port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module dmi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/discretized_mutual_information.sv]
// Top level: histogram counting and fixed-point mutual information of one feature.
//
//  port group   dir  protocol     word
//  in_chan      in   valid/ready  sample_value, class_label, last_sample
//  out_chan     out  valid/ready  mutual_info, sample_count, count_overflow
//  cfg_*        in   APB write    upper_threshold @0, lower_threshold @4
//
// A sample takes one memory read and one write back of the counts.
// The last sample starts an entropy pass of 68 terms, each with a log2 of
// 16 squarings, then a bit-serial divide by the sample count if the sum is positive.
// Reset sets thresholds to defaults and clears all counts, the RAM ones via per-entry valid bits.
// A finished result waits in the output register; new samples are taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module discretized_mutual_information import dmi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  dmi_in_if.sink                 in_chan,
  dmi_out_if.source              out_chan,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready
);

  state_t state_r, state_nxt;

  logic signed [SAMPLE_W-1:0] upper_r, lower_r;
  logic [CNT_W-1:0]       samples_r, samples_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [CNT_W-1:0]       lvl_cnt_r [NUM_LEVELS];
  logic [CNT_W-1:0]       lvl_cnt_nxt [NUM_LEVELS];
  logic [JOINT_DEPTH-1:0] jvld_r, jvld_nxt;
  logic [NUM_CLASSES-1:0] cvld_r, cvld_nxt;
  logic [JOINT_AW-1:0]    jaddr_r, jaddr_nxt;
  logic [CLASS_W-1:0]     cls_r, cls_nxt;
  logic [LEVEL_W-1:0]     lvl_r, lvl_nxt;
  logic                   last_r, last_nxt;

  logic [K_W-1:0]         k_r, k_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic                   neg_r, neg_nxt;
  logic [EXP_W-1:0]       e_r, e_nxt;
  logic [MANT_W-1:0]      m_r, m_nxt;
  logic [FRAC_BITS-1:0]   frac_r, frac_nxt;
  logic [SQ_CNT_W-1:0]    sq_cnt_r, sq_cnt_nxt;
  logic [TERM_W-1:0]      term_r, term_nxt;
  logic [ACC_W-1:0]       plus_r, plus_nxt, minus_r, minus_nxt;
  logic [ACC_W-1:0]       num_r, num_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic                   zero_r, zero_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [MI_W-1:0]  out_mi_r, out_mi_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic                 j_we, c_we;
  logic [JOINT_AW-1:0]  j_raddr;
  logic [CLASS_W-1:0]   c_raddr;
  logic [CNT_W-1:0]     j_rdata, c_rdata, j_base, c_base;
  logic [LEVEL_W-1:0]   in_lvl;
  logic [CNT_W-1:0]     n_sel;
  logic [EXP_W-1:0]     e_sel;
  logic [SQ_W-1:0]      sq;
  logic [MANT_W:0]      sq_top;
  logic [CNT_W:0]       rem_try;
  logic [K_W-1:0]       k_off;

  dmi_ram #(.WIDTH(CNT_W), .DEPTH(JOINT_DEPTH)) u_joint_ram (
    .clk   (clk),
    .we    (j_we),
    .waddr (jaddr_r),
    .wdata (j_base + CNT_W'(1)),
    .raddr (j_raddr),
    .rdata (j_rdata)
  );

  dmi_ram #(.WIDTH(CNT_W), .DEPTH(NUM_CLASSES)) u_class_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (cls_r),
    .wdata (c_base + CNT_W'(1)),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // configuration registers
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= UPPER_RST;
      lower_r <= LOWER_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == REG_LOWER) begin
        lower_r <= cfg_pwdata[SAMPLE_W-1:0];
      end else begin
        upper_r <= cfg_pwdata[SAMPLE_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_UPPER) begin
      cfg_prdata = {{(32-SAMPLE_W){upper_r[SAMPLE_W-1]}}, upper_r};
    end else begin
      cfg_prdata = {{(32-SAMPLE_W){lower_r[SAMPLE_W-1]}}, lower_r};
    end
  end

  always_comb begin
    if (in_chan.sample_value > upper_r) begin
      in_lvl = LVL_ABOVE;
    end else if (in_chan.sample_value < lower_r) begin
      in_lvl = LVL_BELOW;
    end else begin
      in_lvl = LVL_MID;
    end
  end

  assign j_base = jvld_r[jaddr_r] ? j_rdata : '0;
  assign c_base = cvld_r[cls_r] ? c_rdata : '0;
  assign j_we = (state_r == S_UPD);
  assign c_we = (state_r == S_UPD);

  always_comb begin
    if (state_r == S_IDLE) begin
      j_raddr = {in_lvl, in_chan.class_label};
      c_raddr = in_chan.class_label;
    end else begin
      j_raddr = JOINT_AW'(k_r - K_JOINT);
      c_raddr = CLASS_W'(k_r - K_CLASS);
    end
  end

  // term operand for the current pass step
  always_comb begin
    k_off = k_r - K_LEVEL;
    if (k_r == K_TOTAL) begin
      n_sel = samples_r;
    end else if (k_r < K_LEVEL) begin
      n_sel = jvld_r[JOINT_AW'(k_r - K_JOINT)] ? j_rdata : '0;
    end else if (k_r < K_CLASS) begin
      n_sel = lvl_cnt_r[k_off[LEVEL_W-1:0]];
    end else begin
      n_sel = cvld_r[CLASS_W'(k_r - K_CLASS)] ? c_rdata : '0;
    end
    e_sel = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (n_sel[i]) begin
        e_sel = EXP_W'(i);
      end
    end
  end

  assign sq      = SQ_W'(m_r) * SQ_W'(m_r);
  assign sq_top  = sq[MANT_BITS +: MANT_W + 1];
  assign rem_try = {rem_r, num_r[ACC_W-1]};

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.mutual_info    = out_mi_r;
  assign out_chan.sample_count   = out_cnt_r;
  assign out_chan.count_overflow = out_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    samples_nxt   = samples_r;
    ovf_nxt       = ovf_r;
    lvl_cnt_nxt   = lvl_cnt_r;
    jvld_nxt      = jvld_r;
    cvld_nxt      = cvld_r;
    jaddr_nxt     = jaddr_r;
    cls_nxt       = cls_r;
    lvl_nxt       = lvl_r;
    last_nxt      = last_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    neg_nxt       = neg_r;
    e_nxt         = e_r;
    m_nxt         = m_r;
    frac_nxt      = frac_r;
    sq_cnt_nxt    = sq_cnt_r;
    term_nxt      = term_r;
    plus_nxt      = plus_r;
    minus_nxt     = minus_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_mi_nxt    = out_mi_r;
    out_cnt_nxt   = out_cnt_r;
    out_ovf_nxt   = out_ovf_r;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          jaddr_nxt = {in_lvl, in_chan.class_label};
          cls_nxt   = in_chan.class_label;
          lvl_nxt   = in_lvl;
          last_nxt  = in_chan.last_sample;
          k_nxt     = K_TOTAL;
          plus_nxt  = '0;
          minus_nxt = '0;
          if (samples_r == MAX_SAMPLES) begin
            ovf_nxt = 1'b1;
            if (in_chan.last_sample) begin
              state_nxt = S_FRD;
            end
          end else begin
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        jvld_nxt[jaddr_r]  = 1'b1;
        cvld_nxt[cls_r]    = 1'b1;
        lvl_cnt_nxt[lvl_r] = lvl_cnt_r[lvl_r] + CNT_W'(1);
        samples_nxt        = samples_r + CNT_W'(1);
        state_nxt          = last_r ? S_FRD : S_IDLE;
      end
      S_FRD: begin
        state_nxt = S_FLD;
      end
      S_FLD: begin
        n_nxt      = n_sel;
        neg_nxt    = (k_r >= K_LEVEL);
        e_nxt      = e_sel;
        m_nxt      = MANT_W'(n_sel) << (EXP_W'(MANT_BITS) - e_sel);
        frac_nxt   = '0;
        sq_cnt_nxt = '0;
        state_nxt  = S_SQ;
      end
      S_SQ: begin
        if (sq_top[MANT_W]) begin
          m_nxt    = sq_top[MANT_W:1];
          frac_nxt = {frac_r[FRAC_BITS-2:0], 1'b1};
        end else begin
          m_nxt    = sq_top[MANT_W-1:0];
          frac_nxt = {frac_r[FRAC_BITS-2:0], 1'b0};
        end
        sq_cnt_nxt = sq_cnt_r + SQ_CNT_W'(1);
        if (sq_cnt_r == SQ_CNT_W'(FRAC_BITS - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        term_nxt  = TERM_W'(n_r) * TERM_W'({e_r, frac_r});
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (neg_r) begin
          minus_nxt = minus_r + ACC_W'(term_r);
        end else begin
          plus_nxt = plus_r + ACC_W'(term_r);
        end
        k_nxt     = k_r + K_W'(1);
        state_nxt = (k_r == K_LAST) ? S_CHK : S_FRD;
      end
      S_CHK: begin
        zero_nxt    = (plus_r <= minus_r);
        num_nxt     = plus_r - minus_r;
        rem_nxt     = '0;
        div_cnt_nxt = '0;
        state_nxt   = (plus_r <= minus_r) ? S_OUT : S_DIV;
      end
      S_DIV: begin
        if (rem_try >= {1'b0, samples_r}) begin
          rem_nxt = CNT_W'(rem_try - {1'b0, samples_r});
          num_nxt = {num_r[ACC_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_try[CNT_W-1:0];
          num_nxt = {num_r[ACC_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(ACC_W - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          if (zero_r) begin
            out_mi_nxt = '0;
          end else if (|num_r[ACC_W-1:MI_W]) begin
            out_mi_nxt = MI_MAX;
          end else begin
            out_mi_nxt = num_r[MI_W-1:0];
          end
          out_cnt_nxt = samples_r;
          out_ovf_nxt = ovf_r;
          samples_nxt = '0;
          ovf_nxt     = 1'b0;
          jvld_nxt    = '0;
          cvld_nxt    = '0;
          for (int i = 0; i < NUM_LEVELS; i++) begin
            lvl_cnt_nxt[i] = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      samples_r   <= '0;
      ovf_r       <= 1'b0;
      jvld_r      <= '0;
      cvld_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        lvl_cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      samples_r   <= samples_nxt;
      ovf_r       <= ovf_nxt;
      jvld_r      <= jvld_nxt;
      cvld_r      <= cvld_nxt;
      out_valid_r <= out_valid_nxt;
      lvl_cnt_r   <= lvl_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    jaddr_r   <= jaddr_nxt;
    cls_r     <= cls_nxt;
    lvl_r     <= lvl_nxt;
    last_r    <= last_nxt;
    k_r       <= k_nxt;
    n_r       <= n_nxt;
    neg_r     <= neg_nxt;
    e_r       <= e_nxt;
    m_r       <= m_nxt;
    frac_r    <= frac_nxt;
    sq_cnt_r  <= sq_cnt_nxt;
    term_r    <= term_nxt;
    plus_r    <= plus_nxt;
    minus_r   <= minus_nxt;
    num_r     <= num_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    zero_r    <= zero_nxt;
    out_mi_r  <= out_mi_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

endmodule
`default_nettype wire
